// ----- rtl/ddmh_pkg.sv -----
// Shared types, constants and the CORDIC angle table for the
// differential-drive mixer and heading unit. No dependencies.
`default_nettype none

package ddmh_pkg;

   // Configuration register indexes (byte address = 4 * index)
   typedef enum logic [2:0] {
      REG_DEAD_THRESHOLD  = 3'd0,
      REG_JOY_LIMIT       = 3'd1,
      REG_SPEED_MIN       = 3'd2,
      REG_SPEED_MAX       = 3'd3,
      REG_YAW_LIMIT       = 3'd4,
      REG_TIMEOUT_TICKS   = 3'd5,
      REG_SEND_INTERVAL   = 3'd6,
      REG_BODY_PITCH      = 3'd7
   } reg_index_type;

   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // Register reset values
   localparam logic [8:0]  DEAD_THRESHOLD_RST = 9'd20;
   localparam logic [14:0] JOY_LIMIT_RST      = 15'd200;
   localparam logic [14:0] SPEED_MIN_RST      = 15'd0;
   localparam logic [14:0] SPEED_MAX_RST      = 15'd1000;
   localparam logic [6:0]  YAW_LIMIT_RST      = 7'd90;
   localparam logic [15:0] TIMEOUT_RST        = 16'd500;
   localparam logic [15:0] SEND_INTERVAL_RST  = 16'd50;
   localparam logic [7:0]  BODY_PITCH_RST     = 8'd0;

   localparam logic [14:0] INITIAL_SPEED_LIMIT = 15'd1000;

   // Mixer clamp
   localparam int MIX_CLAMP = 200;

   // CORDIC sizing
   localparam int CORDIC_STEPS_DEFAULT = 16;
   localparam int STEPS_PER_STAGE      = 4;
   localparam int ATAN_SIZE            = 24;
   localparam int STEP_W               = 5;
   localparam int ATAN_W               = 23;
   localparam int CX_W                 = 27;
   localparam int Z_W                  = 25;

   // Divide by 400: floor(p / 16) / 25 via reciprocal, exact below 2^21
   localparam int RECIP_SHIFT = 26;
   localparam logic [21:0] RECIP_25 = 22'(((64'd1 << RECIP_SHIFT) + 64'd24) / 64'd25);
   localparam int PROD_W  = 25;
   localparam int QPROD_W = 43;
   localparam int MIX_W   = 17;

   typedef struct packed {
      logic [8:0]  dead_threshold;
      logic [14:0] joy_limit;
      logic [14:0] speed_min;
      logic [14:0] speed_max;
      logic [6:0]  yaw_limit;
      logic [15:0] timeout_ticks;
      logic [15:0] send_interval_ticks;
      logic [7:0]  body_pitch;
   } cfg_type;

   // Item payload carried through the pipeline
   typedef struct packed {
      logic [8:0]               tl;       // left mix plus 200
      logic [8:0]               tr;       // right mix plus 200
      logic [14:0]              lim;
      logic [PROD_W-1:0]        prod_l;
      logic [PROD_W-1:0]        prod_r;
      logic signed [MIX_W-1:0]  mix_l;
      logic signed [MIX_W-1:0]  mix_r;
      logic                     send;
      logic                     moving;
      logic [15:0]              seq;
      logic [7:0]               pitch;
      logic signed [CX_W-1:0]   cx;
      logic signed [CX_W-1:0]   cy;
      logic signed [Z_W-1:0]    cz;
   } pipe_type;

   // atan(2^-i) in degrees, Q16, rounded to nearest
   function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
      logic [ATAN_W-1:0] v;
      case (i)
         5'd0:    v = 23'd2949120;
         5'd1:    v = 23'd1740967;
         5'd2:    v = 23'd919879;
         5'd3:    v = 23'd466945;
         5'd4:    v = 23'd234379;
         5'd5:    v = 23'd117304;
         5'd6:    v = 23'd58666;
         5'd7:    v = 23'd29335;
         5'd8:    v = 23'd14668;
         5'd9:    v = 23'd7334;
         5'd10:   v = 23'd3667;
         5'd11:   v = 23'd1833;
         5'd12:   v = 23'd917;
         5'd13:   v = 23'd458;
         5'd14:   v = 23'd229;
         5'd15:   v = 23'd115;
         5'd16:   v = 23'd57;
         5'd17:   v = 23'd29;
         5'd18:   v = 23'd14;
         5'd19:   v = 23'd7;
         5'd20:   v = 23'd4;
         5'd21:   v = 23'd2;
         5'd22:   v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ddmh_csr.sv -----
// Configuration register file with APB-style access.
// Depends on ddmh_pkg.
`default_nettype none

module ddmh_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [ddmh_pkg::ADDR_W-1:0] paddr,
   input  wire logic [ddmh_pkg::DATA_W-1:0] pwdata,
   output logic      [ddmh_pkg::DATA_W-1:0] prdata,
   output logic                             pready,
   output ddmh_pkg::cfg_type                cfg
);
   import ddmh_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type index;
   logic          write;

   assign index  = reg_index_type'(paddr[ADDR_W-1:2]);
   assign write  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dead_threshold      <= DEAD_THRESHOLD_RST;
         cfg_ff.joy_limit           <= JOY_LIMIT_RST;
         cfg_ff.speed_min           <= SPEED_MIN_RST;
         cfg_ff.speed_max           <= SPEED_MAX_RST;
         cfg_ff.yaw_limit           <= YAW_LIMIT_RST;
         cfg_ff.timeout_ticks       <= TIMEOUT_RST;
         cfg_ff.send_interval_ticks <= SEND_INTERVAL_RST;
         cfg_ff.body_pitch          <= BODY_PITCH_RST;
      end else if (write) begin
         unique case (index)
            REG_DEAD_THRESHOLD: cfg_ff.dead_threshold      <= pwdata[8:0];
            REG_JOY_LIMIT:      cfg_ff.joy_limit           <= pwdata[14:0];
            REG_SPEED_MIN:      cfg_ff.speed_min           <= pwdata[14:0];
            REG_SPEED_MAX:      cfg_ff.speed_max           <= pwdata[14:0];
            REG_YAW_LIMIT:      cfg_ff.yaw_limit           <= pwdata[6:0];
            REG_TIMEOUT_TICKS:  cfg_ff.timeout_ticks       <= pwdata[15:0];
            REG_SEND_INTERVAL:  cfg_ff.send_interval_ticks <= pwdata[15:0];
            REG_BODY_PITCH:     cfg_ff.body_pitch          <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      unique case (index)
         REG_DEAD_THRESHOLD: prdata = 32'(cfg_ff.dead_threshold);
         REG_JOY_LIMIT:      prdata = 32'(cfg_ff.joy_limit);
         REG_SPEED_MIN:      prdata = 32'(cfg_ff.speed_min);
         REG_SPEED_MAX:      prdata = 32'(cfg_ff.speed_max);
         REG_YAW_LIMIT:      prdata = 32'(cfg_ff.yaw_limit);
         REG_TIMEOUT_TICKS:  prdata = 32'(cfg_ff.timeout_ticks);
         REG_SEND_INTERVAL:  prdata = 32'(cfg_ff.send_interval_ticks);
         REG_BODY_PITCH:     prdata = 32'(cfg_ff.body_pitch);
         default:            prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/ddmh_state.sv -----
// Joystick state, ages and command count; takes input items and loads
// the first pipeline register for each tick. Depends on ddmh_pkg.
`default_nettype none

module ddmh_state (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic signed [15:0] req_joy_x,
   input  wire logic signed [15:0] req_joy_y,
   input  wire logic [14:0]        req_speed_request,
   input  ddmh_pkg::cfg_type       cfg,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output ddmh_pkg::pipe_type      out_data
);
   import ddmh_pkg::*;

   logic signed [15:0] stored_x_ff, stored_x_in;
   logic signed [15:0] stored_y_ff, stored_y_in;
   logic [14:0]        speed_limit_ff, speed_limit_in;
   logic [15:0]        receive_age_ff, receive_age_in;
   logic [15:0]        send_age_ff, send_age_in;
   logic [15:0]        command_count_ff, command_count_in;
   logic               valid_ff;
   pipe_type           data_ff, data_in;

   logic               in_ready, accept;
   logic signed [16:0] lim, jx, jy;
   logic signed [15:0] cx_clamp, cy_clamp;
   logic [14:0]        sp_clamp;
   logic [15:0]        ra_next, sa_next;
   logic               timeout, send;
   logic signed [15:0] ex, ey;
   logic [15:0]        ax, ay;
   logic signed [16:0] diff_l, sum_r, cl_l, cl_r;

   assign in_ready  = !valid_ff || out_ready;
   assign req_stall = !in_ready;
   assign accept    = req_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Control item: clamp axes and speed request
   always_comb begin
      lim = signed'({2'b00, cfg.joy_limit});
      jx  = 17'(req_joy_x);
      jy  = 17'(req_joy_y);
      if (jx < -lim)     cx_clamp = 16'(-lim);
      else if (jx > lim) cx_clamp = 16'(lim);
      else               cx_clamp = req_joy_x;
      if (jy < -lim)     cy_clamp = 16'(-lim);
      else if (jy > lim) cy_clamp = 16'(lim);
      else               cy_clamp = req_joy_y;
      if (req_speed_request < cfg.speed_min)      sp_clamp = cfg.speed_min;
      else if (req_speed_request > cfg.speed_max) sp_clamp = cfg.speed_max;
      else                                        sp_clamp = req_speed_request;
   end

   // Tick: ages, timeout, mix terms and heading setup
   always_comb begin
      ra_next = (receive_age_ff == 16'hFFFF) ? receive_age_ff : receive_age_ff + 16'd1;
      sa_next = (send_age_ff == 16'hFFFF) ? send_age_ff : send_age_ff + 16'd1;
      timeout = ra_next > cfg.timeout_ticks;
      send    = sa_next > cfg.send_interval_ticks;
      ex      = timeout ? 16'sd0 : stored_x_ff;
      ey      = timeout ? 16'sd0 : stored_y_ff;
      ax      = ex[15] ? 16'(-ex) : 16'(ex);
      ay      = ey[15] ? 16'(-ey) : 16'(ey);

      diff_l = 17'(ey) - 17'(ex);
      sum_r  = 17'(ey) + 17'(ex);
      if (diff_l < -17'sd200)     cl_l = -17'sd200;
      else if (diff_l > 17'sd200) cl_l = 17'sd200;
      else                        cl_l = diff_l;
      if (sum_r < -17'sd200)      cl_r = -17'sd200;
      else if (sum_r > 17'sd200)  cl_r = 17'sd200;
      else                        cl_r = sum_r;

      data_in        = data_ff;
      data_in.tl     = 9'(cl_l + 17'(MIX_CLAMP));
      data_in.tr     = 9'(cl_r + 17'(MIX_CLAMP));
      data_in.lim    = speed_limit_ff;
      data_in.prod_l = '0;
      data_in.prod_r = '0;
      data_in.mix_l  = '0;
      data_in.mix_r  = '0;
      data_in.send   = send;
      data_in.moving = (ax > {7'd0, cfg.dead_threshold}) ||
                       (ay > {7'd0, cfg.dead_threshold});
      data_in.seq    = command_count_ff;
      data_in.pitch  = cfg.body_pitch;
      data_in.cx     = signed'({3'b000, ay, 8'h00});
      data_in.cy     = signed'({{3{ex[15]}}, ex, 8'h00});
      data_in.cz     = '0;
   end

   // Next state
   always_comb begin
      stored_x_in      = stored_x_ff;
      stored_y_in      = stored_y_ff;
      speed_limit_in   = speed_limit_ff;
      receive_age_in   = receive_age_ff;
      send_age_in      = send_age_ff;
      command_count_in = command_count_ff;
      if (accept) begin
         if (!req_action) begin
            stored_x_in    = cx_clamp;
            stored_y_in    = cy_clamp;
            speed_limit_in = sp_clamp;
            receive_age_in = '0;
         end else begin
            stored_x_in    = ex;
            stored_y_in    = ey;
            receive_age_in = ra_next;
            send_age_in    = send ? 16'd0 : sa_next;
            if (send) command_count_in = command_count_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stored_x_ff      <= '0;
         stored_y_ff      <= '0;
         speed_limit_ff   <= INITIAL_SPEED_LIMIT;
         receive_age_ff   <= '0;
         send_age_ff      <= '0;
         command_count_ff <= '0;
         valid_ff         <= 1'b0;
      end else begin
         stored_x_ff      <= stored_x_in;
         stored_y_ff      <= stored_y_in;
         speed_limit_ff   <= speed_limit_in;
         receive_age_ff   <= receive_age_in;
         send_age_ff      <= send_age_in;
         command_count_ff <= command_count_in;
         if (in_ready) valid_ff <= req_valid && req_action;
      end
   end

   // Payload register, loaded on every accepted tick
   always_ff @(posedge clock) begin
      if (accept && req_action) data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ----- rtl/ddmh_stage.sv -----
// One pipeline stage: a group of CORDIC vectoring steps, and in the first
// two stages the speed map multiply and divide. Depends on ddmh_pkg.
`default_nettype none

module ddmh_stage #(
   parameter int STAGE_INDEX  = 0,
   parameter int FIRST_STEP   = 0,
   parameter int CORDIC_STEPS = ddmh_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  ddmh_pkg::pipe_type in_data,
   output logic               out_valid,
   input  wire logic          out_ready,
   output ddmh_pkg::pipe_type out_data
);
   import ddmh_pkg::*;

   logic     valid_ff;
   pipe_type data_ff, data_in;

   logic signed [CX_W-1:0] cx, cy, sx, sy;
   logic signed [Z_W-1:0]  cz;
   logic [QPROD_W-1:0]     qprod_l, qprod_r;
   logic [16:0]            quot_l, quot_r;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   // Speed map: product in the first stage, divide by 400 in the second
   always_comb begin
      qprod_l = QPROD_W'(in_data.prod_l[PROD_W-1:4]) * QPROD_W'(RECIP_25);
      qprod_r = QPROD_W'(in_data.prod_r[PROD_W-1:4]) * QPROD_W'(RECIP_25);
      quot_l  = qprod_l[RECIP_SHIFT +: 17];
      quot_r  = qprod_r[RECIP_SHIFT +: 17];
   end

   // CORDIC steps of this stage
   always_comb begin
      data_in = in_data;
      cx = in_data.cx;
      cy = in_data.cy;
      cz = in_data.cz;
      sx = '0;
      sy = '0;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
         if (FIRST_STEP + j < CORDIC_STEPS) begin
            sx = cx >>> (FIRST_STEP + j);
            sy = cy >>> (FIRST_STEP + j);
            if (!cy[CX_W-1]) begin
               cx = cx + sy;
               cy = cy - sx;
               cz = cz + signed'({2'b00, atan_q16(STEP_W'(FIRST_STEP + j))});
            end else begin
               cx = cx - sy;
               cy = cy + sx;
               cz = cz - signed'({2'b00, atan_q16(STEP_W'(FIRST_STEP + j))});
            end
         end
      end
      data_in.cx = cx;
      data_in.cy = cy;
      data_in.cz = cz;

      if (STAGE_INDEX == 0) begin
         data_in.prod_l = PROD_W'(in_data.tl) * PROD_W'({in_data.lim, 1'b0});
         data_in.prod_r = PROD_W'(in_data.tr) * PROD_W'({in_data.lim, 1'b0});
      end
      if (STAGE_INDEX == 1) begin
         data_in.mix_l = MIX_W'(signed'({1'b0, quot_l}) - signed'({3'b000, in_data.lim}));
         data_in.mix_r = MIX_W'(signed'({1'b0, quot_r}) - signed'({3'b000, in_data.lim}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) data_ff <= data_in;
   end

endmodule

`default_nettype wire

// ----- rtl/ddmh_output.sv -----
// Result register: rounds and clamps the heading, forms the four wheel
// speeds and masks the heading fields. Depends on ddmh_pkg.
`default_nettype none

module ddmh_output (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  ddmh_pkg::pipe_type      in_data,
   input  ddmh_pkg::cfg_type       cfg,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_left_speed,
   output logic signed [15:0]      rsp_right_speed,
   output logic signed [15:0]      rsp_rear_left_speed,
   output logic signed [15:0]      rsp_rear_right_speed,
   output logic                    rsp_heading_valid,
   output logic [15:0]             rsp_heading_sequence,
   output logic                    rsp_heading_moving,
   output logic signed [7:0]       rsp_heading_yaw,
   output logic signed [7:0]       rsp_heading_pitch
);
   import ddmh_pkg::*;

   logic               valid_ff;
   logic signed [15:0] left_ff, right_ff, rear_left_ff, rear_right_ff;
   logic               hvalid_ff, moving_ff;
   logic [15:0]        seq_ff;
   logic signed [7:0]  yaw_ff, pitch_ff;

   logic [Z_W:0]       zabs, zrnd;
   logic [9:0]         mag;
   logic [7:0]         magc;
   logic signed [7:0]  yaw;

   assign in_ready = !valid_ff || !rsp_stall;

   // Round Q16 degrees half away from zero, clamp to the yaw limit, zero when not moving
   always_comb begin
      zabs = in_data.cz[Z_W-1] ? (Z_W+1)'(-in_data.cz) : (Z_W+1)'(in_data.cz);
      zrnd = zabs + (Z_W+1)'(32768);
      mag  = zrnd[25:16];
      magc = (mag > {3'b000, cfg.yaw_limit}) ? {1'b0, cfg.yaw_limit} : mag[7:0];
      if (!in_data.moving)        yaw = 8'sd0;
      else if (in_data.cz[Z_W-1]) yaw = signed'(8'(-magc));
      else                        yaw = signed'(magc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         left_ff       <= in_data.mix_l[15:0];
         right_ff      <= 16'(-in_data.mix_r);
         rear_left_ff  <= 16'(-in_data.mix_l);
         rear_right_ff <= in_data.mix_r[15:0];
         hvalid_ff     <= in_data.send;
         seq_ff        <= in_data.send ? in_data.seq : 16'd0;
         moving_ff     <= in_data.send && in_data.moving;
         yaw_ff        <= in_data.send ? yaw : 8'sd0;
         pitch_ff      <= in_data.send ? in_data.pitch : 8'sd0;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_left_speed       = left_ff;
   assign rsp_right_speed      = right_ff;
   assign rsp_rear_left_speed  = rear_left_ff;
   assign rsp_rear_right_speed = rear_right_ff;
   assign rsp_heading_valid    = hvalid_ff;
   assign rsp_heading_sequence = seq_ff;
   assign rsp_heading_moving   = moving_ff;
   assign rsp_heading_yaw      = yaw_ff;
   assign rsp_heading_pitch    = pitch_ff;

endmodule

`default_nettype wire

// ----- rtl/differential_drive_mixer_heading_unit.sv -----
// Top level of the differential-drive mixer and heading unit.
// Depends on ddmh_pkg, ddmh_csr, ddmh_state, ddmh_stage, ddmh_output.
//
// Takes one item per clock while req_stall is low: a control item
// (action 0) updates the stored joystick and speed limit and gives no
// result; a tick (action 1) gives one result of four wheel speeds and an
// optional heading command. The item passes the state register, one
// register per group of four CORDIC steps, and the result register.
// Throughput is one item per cycle while no stall holds the pipeline, set
// by the CORDIC stage pipeline; the stages keep moving under output stall
// until each register is full.
// Configuration is written through an APB-style port at byte address 4*i.
`default_nettype none

module differential_drive_mixer_heading_unit #(
   parameter int CORDIC_STEPS = ddmh_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_action,
   input  wire logic signed [15:0]          req_joy_x,
   input  wire logic signed [15:0]          req_joy_y,
   input  wire logic [14:0]                 req_speed_request,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic signed [15:0]               rsp_left_speed,
   output logic signed [15:0]               rsp_right_speed,
   output logic signed [15:0]               rsp_rear_left_speed,
   output logic signed [15:0]               rsp_rear_right_speed,
   output logic                             rsp_heading_valid,
   output logic [15:0]                      rsp_heading_sequence,
   output logic                             rsp_heading_moving,
   output logic signed [7:0]                rsp_heading_yaw,
   output logic signed [7:0]                rsp_heading_pitch,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [ddmh_pkg::ADDR_W-1:0] paddr,
   input  wire logic [ddmh_pkg::DATA_W-1:0] pwdata,
   output logic      [ddmh_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);
   import ddmh_pkg::*;

   localparam int NUM_STAGES = (CORDIC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

   cfg_type                 cfg;
   pipe_type                link_data  [0:NUM_STAGES];
   logic [NUM_STAGES:0]     link_valid;
   logic [NUM_STAGES:0]     link_ready;

   // Configuration registers
   ddmh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // State update and first pipeline register
   ddmh_state u_state (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_joy_x         (req_joy_x),
      .req_joy_y         (req_joy_y),
      .req_speed_request (req_speed_request),
      .cfg               (cfg),
      .out_valid         (link_valid[0]),
      .out_ready         (link_ready[0]),
      .out_data          (link_data[0])
   );

   // CORDIC and speed map stages
   for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
      ddmh_stage #(
         .STAGE_INDEX  (k),
         .FIRST_STEP   (k * STEPS_PER_STAGE),
         .CORDIC_STEPS (CORDIC_STEPS)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_ready  (link_ready[k]),
         .in_data   (link_data[k]),
         .out_valid (link_valid[k+1]),
         .out_ready (link_ready[k+1]),
         .out_data  (link_data[k+1])
      );
   end

   // Result register
   ddmh_output u_output (
      .clock                (clock),
      .reset                (reset),
      .in_valid             (link_valid[NUM_STAGES]),
      .in_ready             (link_ready[NUM_STAGES]),
      .in_data              (link_data[NUM_STAGES]),
      .cfg                  (cfg),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_left_speed       (rsp_left_speed),
      .rsp_right_speed      (rsp_right_speed),
      .rsp_rear_left_speed  (rsp_rear_left_speed),
      .rsp_rear_right_speed (rsp_rear_right_speed),
      .rsp_heading_valid    (rsp_heading_valid),
      .rsp_heading_sequence (rsp_heading_sequence),
      .rsp_heading_moving   (rsp_heading_moving),
      .rsp_heading_yaw      (rsp_heading_yaw),
      .rsp_heading_pitch    (rsp_heading_pitch)
   );

endmodule

`default_nettype wire
